FILE: hdl/isc_pkg.sv
// shared types, constants and helpers for the imu sample scale and calibrate block
package isc_pkg;

   localparam int RAW_W       = 16;
   localparam int SCALE_W     = 16;
   localparam int SAMPLES_W   = 13;
   localparam int DATA_W      = 24;
   localparam int CSR_W       = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int NUM_AXES    = 6;
   localparam int SAT_IN_W    = 48;
   localparam int TEMP_RECIP_W = 25;

   localparam int DEF_MAX_CAL_SAMPLES = 4096;
   localparam int DEF_OUT_FRAC_BITS   = 16;

   // 1/333.87 as a fraction of 2^32
   localparam logic signed [TEMP_RECIP_W-1:0] TEMP_RECIP = 25'sd12864191;
   localparam int TEMP_BASE = 21;

   localparam logic [SCALE_W-1:0]   ACCEL_SCALE_RST = 16'd8192;
   localparam logic [SCALE_W-1:0]   GYRO_SCALE_RST  = 16'd17872;
   localparam logic [SAMPLES_W-1:0] CAL_SAMPLES_RST = 13'd256;

   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_SCALE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_SCALE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_SAMPLES = 2'd2;

   typedef enum logic [1:0] {
      FUNC_CONVERT = 2'd0,
      FUNC_CAL     = 2'd1,
      FUNC_CLEAR   = 2'd2
   } func_type;

   typedef logic signed [DATA_W-1:0] sample_type;

   typedef struct packed {
      func_type                 func;
      logic signed [RAW_W-1:0]  accel_x_raw;
      logic signed [RAW_W-1:0]  accel_y_raw;
      logic signed [RAW_W-1:0]  accel_z_raw;
      logic signed [RAW_W-1:0]  temp_word;
      logic signed [RAW_W-1:0]  gyro_x_raw;
      logic signed [RAW_W-1:0]  gyro_y_raw;
      logic signed [RAW_W-1:0]  gyro_z_raw;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] accel_x;
      logic signed [DATA_W-1:0] accel_y;
      logic signed [DATA_W-1:0] accel_z;
      logic signed [DATA_W-1:0] gyro_x;
      logic signed [DATA_W-1:0] gyro_y;
      logic signed [DATA_W-1:0] gyro_z;
      logic signed [DATA_W-1:0] temperature;
      logic                     calibrated;
      logic                     cal_done;
   } rsp_payload_type;

   // per-cycle commands from the sequencer to the lanes
   typedef struct packed {
      logic mul;
      logic acc;
      logic cal_add;
      logic clear;
      logic div_load;
      logic div_step;
      logic fix;
   } lane_ctl_type;

   function automatic logic signed [DATA_W-1:0] sat24(input logic signed [SAT_IN_W-1:0] v);
      logic signed [SAT_IN_W-1:0] hi;
      logic signed [SAT_IN_W-1:0] lo;
      hi = SAT_IN_W'((1 <<< (DATA_W - 1)) - 1);
      lo = -SAT_IN_W'(1 <<< (DATA_W - 1));
      if (v > hi) begin
         return hi[DATA_W-1:0];
      end else if (v < lo) begin
         return lo[DATA_W-1:0];
      end
      return v[DATA_W-1:0];
   endfunction

endpackage

FILE: hdl/isc_axis_lane.sv
// one sensor axis: gain multiply, rounding, offset correction, accumulator and serial divider
module isc_axis_lane import isc_pkg::*; #(
   parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS,
   parameter int SUM_W         = 37,
   parameter int CNT_W         = 13,
   parameter int OFS_BIAS      = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lane_ctl_type             ctl,
   input  logic signed [RAW_W-1:0]  raw,
   input  logic [SCALE_W-1:0]       scale,
   input  logic [CNT_W-1:0]         divisor,
   output sample_type               corr
);

   localparam int SH     = DATA_W - OUT_FRAC_BITS;
   localparam int PROD_W = RAW_W + SCALE_W + 1;
   localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1 << (SH - 1));

   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [PROD_W-1:0]   rnd;
   sample_type                 scaled;
   sample_type                 corr_ff, corr_in;
   sample_type                 off_ff, off_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [SUM_W-1:0]           mag;
   logic [SUM_W-1:0]           dvd_ff, dvd_in;
   logic [CNT_W-1:0]           rem_ff, rem_in;
   logic [CNT_W:0]             rem_sh;
   logic                       neg_ff, neg_in;
   logic signed [SAT_IN_W-1:0] qext;
   logic signed [SAT_IN_W-1:0] qval;
   sample_type                 qsat;

   always_comb begin
      prod_in = prod_ff;
      if (ctl.mul) begin
         prod_in = raw * $signed({1'b0, scale});
      end
   end

   // round half up then floor shift
   assign rnd    = (prod_ff + HALF) >>> SH;
   assign scaled = sat24(SAT_IN_W'(rnd));

   always_comb begin
      corr_in = corr_ff;
      if (ctl.acc) begin
         corr_in = sat24(SAT_IN_W'(scaled) - SAT_IN_W'(off_ff));
      end
   end

   assign mag    = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign rem_sh = {rem_ff, dvd_ff[SUM_W-1]};

   assign qext = $signed(SAT_IN_W'(dvd_ff));
   assign qval = neg_ff ? -qext : qext;
   assign qsat = sat24(qval);

   always_comb begin
      sum_in = sum_ff;
      off_in = off_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      neg_in = neg_ff;
      if (ctl.clear) begin
         sum_in = '0;
         off_in = '0;
      end else if (ctl.cal_add) begin
         sum_in = sum_ff + SUM_W'(scaled);
      end
      if (ctl.div_load) begin
         neg_in = sum_ff[SUM_W-1];
         dvd_in = mag + SUM_W'(divisor >> 1);
         rem_in = '0;
      end
      // restoring division, one quotient bit per step
      if (ctl.div_step) begin
         if (rem_sh >= {1'b0, divisor}) begin
            rem_in = CNT_W'(rem_sh - {1'b0, divisor});
            dvd_in = {dvd_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[CNT_W-1:0];
            dvd_in = {dvd_ff[SUM_W-2:0], 1'b0};
         end
      end
      if (ctl.fix) begin
         off_in = sat24(SAT_IN_W'(qsat) - SAT_IN_W'(OFS_BIAS));
         sum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      corr_ff <= corr_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
      if (reset) begin
         sum_ff <= '0;
         off_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         off_ff <= off_in;
      end
   end

   assign corr = corr_ff;

endmodule

FILE: hdl/isc_temp.sv
// temperature conversion: raw times 1/333.87, rounded, plus 21 degrees
module isc_temp import isc_pkg::*; #(
   parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS
) (
   input  logic                    clock,
   input  lane_ctl_type            ctl,
   input  logic signed [RAW_W-1:0] raw,
   output sample_type              temperature
);

   localparam int SH     = 32 - OUT_FRAC_BITS;
   localparam int PROD_W = RAW_W + TEMP_RECIP_W;
   localparam logic signed [PROD_W-1:0]   HALF = PROD_W'(1 << (SH - 1));
   localparam logic signed [SAT_IN_W-1:0] BASE = SAT_IN_W'(TEMP_BASE) <<< OUT_FRAC_BITS;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0] rnd;
   sample_type               temp_ff, temp_in;

   assign rnd = (prod_ff + HALF) >>> SH;

   always_comb begin
      prod_in = prod_ff;
      temp_in = temp_ff;
      if (ctl.mul) begin
         prod_in = raw * TEMP_RECIP;
      end
      if (ctl.acc) begin
         temp_in = sat24(SAT_IN_W'(rnd) + BASE);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      temp_ff <= temp_in;
   end

   assign temperature = temp_ff;

endmodule

FILE: hdl/isc_merge.sv
// merges lane results and flags into the registered result transfer
module isc_merge import isc_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  sample_type [NUM_AXES-1:0]     corr,
   input  sample_type                    temperature,
   input  logic                          calibrated,
   input  logic                          cal_done,
   output logic                          can_load,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output rsp_payload_type               rsp_data
);

   logic            valid_ff, valid_in;
   rsp_payload_type data_ff, data_in;
   logic            take;

   assign can_load = !valid_ff || rsp_ready;
   assign take     = load && can_load;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (take) begin
         valid_in            = 1'b1;
         data_in.accel_x     = corr[0];
         data_in.accel_y     = corr[1];
         data_in.accel_z     = corr[2];
         data_in.gyro_x      = corr[3];
         data_in.gyro_y      = corr[4];
         data_in.gyro_z      = corr[5];
         data_in.temperature = temperature;
         data_in.calibrated  = calibrated;
         data_in.cal_done    = cal_done;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: hdl/imu_sample_scale_and_offset_calibrate_top.sv
// top level: sequencer, config registers, six axis lanes, temperature path and result merge
// requests pass the multiply, accumulate and output states; a calibrate item that ends a run
// also passes load, divide and fix, its offset divisions running bit-serially side by side in the lanes
// one item in flight: no new request is taken until the result has been loaded for output
// synchronous active-high reset: scales and run length to defaults, offsets, sums, count and
// calibrated flag to zero, no result pending
module imu_sample_scale_and_offset_calibrate_top import isc_pkg::*; #(
   parameter int MAX_CAL_SAMPLES = DEF_MAX_CAL_SAMPLES,
   parameter int OUT_FRAC_BITS   = DEF_OUT_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata
);

   // count wide enough to hold the run length, sums wide enough for a full run
   localparam int CNT_W = $clog2(MAX_CAL_SAMPLES + 1);
   localparam int SUM_W = DATA_W + $clog2(MAX_CAL_SAMPLES) + 1;
   localparam int CMP_W = (CNT_W > SAMPLES_W) ? CNT_W : SAMPLES_W;
   localparam int IT_W  = $clog2(SUM_W);
   localparam int ONE_G = 1 << OUT_FRAC_BITS;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_MUL  = 7'b0000010,
      S_ACC  = 7'b0000100,
      S_LOAD = 7'b0001000,
      S_DIV  = 7'b0010000,
      S_FIX  = 7'b0100000,
      S_OUT  = 7'b1000000
   } state_type;

   state_type              state_ff, state_in;
   req_payload_type        req_ff, req_in;
   logic [SCALE_W-1:0]     accel_scale_ff, accel_scale_in;
   logic [SCALE_W-1:0]     gyro_scale_ff, gyro_scale_in;
   logic [SAMPLES_W-1:0]   cal_samples_ff, cal_samples_in;
   logic [CNT_W-1:0]       cal_count_ff, cal_count_in;
   logic [CNT_W-1:0]       div_cnt_ff, div_cnt_in;
   logic [IT_W-1:0]        it_ff, it_in;
   logic                   calibrated_ff, calibrated_in;
   logic                   done_ff, done_in;
   logic [CMP_W-1:0]       run_len;
   logic [CMP_W-1:0]       cnt_next;
   logic                   finishing;
   logic                   req_xfer;
   logic                   can_load;
   lane_ctl_type           ctl;
   sample_type [NUM_AXES-1:0] corr;
   sample_type             temperature;
   logic signed [RAW_W-1:0] lane_raw [NUM_AXES];

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;

   // run length clamped to 1..MAX_CAL_SAMPLES
   always_comb begin
      if (cal_samples_ff == '0) begin
         run_len = CMP_W'(1);
      end else if (CMP_W'(cal_samples_ff) > CMP_W'(MAX_CAL_SAMPLES)) begin
         run_len = CMP_W'(MAX_CAL_SAMPLES);
      end else begin
         run_len = CMP_W'(cal_samples_ff);
      end
   end

   assign cnt_next  = CMP_W'(cal_count_ff) + CMP_W'(1);
   assign finishing = (req_ff.func == FUNC_CAL) && (cnt_next >= run_len);

   // lane commands
   always_comb begin
      ctl          = '0;
      ctl.mul      = (state_ff == S_MUL);
      ctl.acc      = (state_ff == S_ACC);
      ctl.cal_add  = (state_ff == S_ACC) && (req_ff.func == FUNC_CAL);
      ctl.clear    = (state_ff == S_ACC) && (req_ff.func == FUNC_CLEAR);
      ctl.div_load = (state_ff == S_LOAD);
      ctl.div_step = (state_ff == S_DIV);
      ctl.fix      = (state_ff == S_FIX);
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      cal_count_in  = cal_count_ff;
      div_cnt_in    = div_cnt_ff;
      it_in         = it_ff;
      calibrated_in = calibrated_ff;
      done_in       = done_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               req_in   = req_data;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            done_in  = finishing;
            state_in = S_OUT;
            unique case (req_ff.func)
               FUNC_CAL: begin
                  if (finishing) begin
                     cal_count_in = '0;
                     div_cnt_in   = CNT_W'(cnt_next);
                     state_in     = S_LOAD;
                  end else begin
                     cal_count_in = CNT_W'(cnt_next);
                  end
               end
               FUNC_CLEAR: begin
                  cal_count_in  = '0;
                  calibrated_in = 1'b0;
               end
               default: begin
                  // convert only, the unused code included
               end
            endcase
         end
         S_LOAD: begin
            it_in    = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            it_in = it_ff + IT_W'(1);
            if (it_ff == IT_W'(SUM_W - 1)) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            calibrated_in = 1'b1;
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (can_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // configuration writes
   always_comb begin
      accel_scale_in = accel_scale_ff;
      gyro_scale_in  = gyro_scale_ff;
      cal_samples_in = cal_samples_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ACCEL_SCALE: accel_scale_in = csr_wdata[SCALE_W-1:0];
            CSR_GYRO_SCALE:  gyro_scale_in  = csr_wdata[SCALE_W-1:0];
            CSR_CAL_SAMPLES: cal_samples_in = csr_wdata[SAMPLES_W-1:0];
            default: begin
               // no register at this index
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      div_cnt_ff <= div_cnt_in;
      it_ff      <= it_in;
      done_ff    <= done_in;
      if (reset) begin
         state_ff       <= S_IDLE;
         accel_scale_ff <= ACCEL_SCALE_RST;
         gyro_scale_ff  <= GYRO_SCALE_RST;
         cal_samples_ff <= CAL_SAMPLES_RST;
         cal_count_ff   <= '0;
         calibrated_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         accel_scale_ff <= accel_scale_in;
         gyro_scale_ff  <= gyro_scale_in;
         cal_samples_ff <= cal_samples_in;
         cal_count_ff   <= cal_count_in;
         calibrated_ff  <= calibrated_in;
      end
   end

   // sensor order: accel x y z, gyro x y z
   assign lane_raw[0] = req_ff.accel_x_raw;
   assign lane_raw[1] = req_ff.accel_y_raw;
   assign lane_raw[2] = req_ff.accel_z_raw;
   assign lane_raw[3] = req_ff.gyro_x_raw;
   assign lane_raw[4] = req_ff.gyro_y_raw;
   assign lane_raw[5] = req_ff.gyro_z_raw;

   for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
      // accel z offset carries one g so a level device reads +1 g
      isc_axis_lane #(
         .OUT_FRAC_BITS (OUT_FRAC_BITS),
         .SUM_W         (SUM_W),
         .CNT_W         (CNT_W),
         .OFS_BIAS      ((i == 2) ? ONE_G : 0)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .raw     (lane_raw[i]),
         .scale   ((i < 3) ? accel_scale_ff : gyro_scale_ff),
         .divisor (div_cnt_ff),
         .corr    (corr[i])
      );
   end

   isc_temp #(
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_temp (
      .clock       (clock),
      .ctl         (ctl),
      .raw         (req_ff.temp_word),
      .temperature (temperature)
   );

   isc_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .load        (state_ff == S_OUT),
      .corr        (corr),
      .temperature (temperature),
      .calibrated  (calibrated_ff),
      .cal_done    (done_ff),
      .can_load    (can_load),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

FILE: hdl/isc_checker.sv
// port-level checks for the imu sample scale and calibrate block, bound to the top level
module isc_checker import isc_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rsp_payload_type       rsp_data
);

   // a stalled result transfer keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // a run can only complete with the calibrated flag set
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_data.cal_done || rsp_data.calibrated)
      else $error("cal_done without calibrated");

   // reset leaves no result pending
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // one item in flight: a request transfer closes the input side
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

endmodule

bind imu_sample_scale_and_offset_calibrate_top isc_checker u_isc_checker (.*);

FILE: tb/isc_frame_checker.sv
// frame checker: watches the imu block's channels, predicts each result and compares it
`timescale 1ns / 100ps
module isc_frame_checker import isc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_payload_type       req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_payload_type       rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata,
   output int unsigned           fail_count,
   output int unsigned           outstanding
);

   localparam longint SAT_MAX = (longint'(1) <<< (DATA_W - 1)) - 1;
   localparam longint SAT_MIN = -(longint'(1) <<< (DATA_W - 1));

   // copy of the block's registers and calibration state
   logic [SCALE_W-1:0]   accel_gain;
   logic [SCALE_W-1:0]   gyro_gain;
   logic [SAMPLES_W-1:0] run_len;
   longint               axis_offset [NUM_AXES];
   longint               axis_sum [NUM_AXES];
   int unsigned          run_count;
   bit                   cal_flag;

   rsp_payload_type      expected_frames [$];
   rsp_payload_type      want;

   function automatic longint clip24(input longint v);
      if (v > SAT_MAX) begin
         return SAT_MAX;
      end else if (v < SAT_MIN) begin
         return SAT_MIN;
      end
      return v;
   endfunction

   // add half then floor shift
   function automatic longint round_down(input longint v, input int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   // magnitude divided with half away from zero, sign restored
   function automatic longint offset_avg(input longint s, input int unsigned n);
      longint mag;
      longint q;
      mag = (s < 0) ? -s : s;
      q = (mag + longint'(n / 2)) / longint'(n);
      return clip24((s < 0) ? -q : q);
   endfunction

   function automatic void clear_run(input bit offsets_too);
      int i;
      for (i = 0; i < NUM_AXES; i++) begin
         axis_sum[i] = 0;
         if (offsets_too) begin
            axis_offset[i] = 0;
         end
      end
      run_count = 0;
   endfunction

   function automatic rsp_payload_type predict_frame(input req_payload_type p);
      longint          raw [NUM_AXES];
      longint          scaled [NUM_AXES];
      longint          corr [NUM_AXES];
      longint          gain;
      longint          temp_q;
      int unsigned     limit;
      bit              done;
      int              i;
      rsp_payload_type r;
      raw[0] = p.accel_x_raw;
      raw[1] = p.accel_y_raw;
      raw[2] = p.accel_z_raw;
      raw[3] = p.gyro_x_raw;
      raw[4] = p.gyro_y_raw;
      raw[5] = p.gyro_z_raw;
      done = 1'b0;
      for (i = 0; i < NUM_AXES; i++) begin
         gain = (i < 3) ? longint'(accel_gain) : longint'(gyro_gain);
         scaled[i] = clip24(round_down(raw[i] * gain, 24 - DEF_OUT_FRAC_BITS));
         corr[i] = clip24(scaled[i] - axis_offset[i]);
      end
      temp_q = round_down(longint'(p.temp_word) * longint'(TEMP_RECIP), 32 - DEF_OUT_FRAC_BITS);
      temp_q = clip24(temp_q + (longint'(TEMP_BASE) <<< DEF_OUT_FRAC_BITS));

      if (p.func == FUNC_CAL) begin
         limit = run_len;
         if (limit == 0) begin
            limit = 1;
         end
         if (limit > DEF_MAX_CAL_SAMPLES) begin
            limit = DEF_MAX_CAL_SAMPLES;
         end
         for (i = 0; i < NUM_AXES; i++) begin
            axis_sum[i] += scaled[i];
         end
         run_count++;
         if (run_count >= limit) begin
            for (i = 0; i < NUM_AXES; i++) begin
               axis_offset[i] = offset_avg(axis_sum[i], run_count);
            end
            // one g off the z offset
            axis_offset[2] = clip24(axis_offset[2] - (longint'(1) <<< DEF_OUT_FRAC_BITS));
            clear_run(1'b0);
            cal_flag = 1'b1;
            done = 1'b1;
         end
      end else if (p.func == FUNC_CLEAR) begin
         clear_run(1'b1);
         cal_flag = 1'b0;
      end

      r.accel_x     = corr[0][DATA_W-1:0];
      r.accel_y     = corr[1][DATA_W-1:0];
      r.accel_z     = corr[2][DATA_W-1:0];
      r.gyro_x      = corr[3][DATA_W-1:0];
      r.gyro_y      = corr[4][DATA_W-1:0];
      r.gyro_z      = corr[5][DATA_W-1:0];
      r.temperature = temp_q[DATA_W-1:0];
      r.calibrated  = cal_flag;
      r.cal_done    = done;
      return r;
   endfunction

   task automatic compare_field(input string name, input logic signed [DATA_W-1:0] exp_v,
                                input logic signed [DATA_W-1:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         accel_gain = ACCEL_SCALE_RST;
         gyro_gain  = GYRO_SCALE_RST;
         run_len    = CAL_SAMPLES_RST;
         clear_run(1'b1);
         cal_flag   = 1'b0;
         expected_frames.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ACCEL_SCALE: accel_gain = csr_wdata[SCALE_W-1:0];
               CSR_GYRO_SCALE:  gyro_gain  = csr_wdata[SCALE_W-1:0];
               CSR_CAL_SAMPLES: run_len    = csr_wdata[SAMPLES_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_frames.size() == 0) begin
               $display("%0t ns: result transfer with nothing expected, actual %h", $time,
                        rsp_data);
               fail_count++;
            end else begin
               want = expected_frames.pop_front();
               compare_field("accel_x", want.accel_x, rsp_data.accel_x);
               compare_field("accel_y", want.accel_y, rsp_data.accel_y);
               compare_field("accel_z", want.accel_z, rsp_data.accel_z);
               compare_field("gyro_x", want.gyro_x, rsp_data.gyro_x);
               compare_field("gyro_y", want.gyro_y, rsp_data.gyro_y);
               compare_field("gyro_z", want.gyro_z, rsp_data.gyro_z);
               compare_field("temperature", want.temperature, rsp_data.temperature);
               compare_field("calibrated", DATA_W'(want.calibrated), DATA_W'(rsp_data.calibrated));
               compare_field("cal_done", DATA_W'(want.cal_done), DATA_W'(rsp_data.cal_done));
            end
         end
         if (req_valid && req_ready) begin
            expected_frames.push_back(predict_frame(req_data));
         end
      end
      outstanding = expected_frames.size();
   end

endmodule

FILE: tb/tb_imu_sample_scale_and_offset_calibrate_top.sv
// testbench top: clock, reset, frame stimulus, register writes and verdict for the imu block
`timescale 1ns / 100ps
module tb_imu_sample_scale_and_offset_calibrate_top import isc_pkg::*;;

   localparam int                      IDLE_PCT      = 27;
   localparam int                      SETTLE_CYCLES = 8;
   localparam longint unsigned         CYCLE_LIMIT   = 500000;
   localparam int                      RAND_PHASES   = 12;
   localparam int                      PHASE_ITEMS   = 78;
   localparam int                      CALM_PHASE    = 6;
   localparam int                      LONG_PHASE    = 4;
   localparam int                      ZERO_PHASE    = 9;
   localparam logic [1:0]              FUNC_RESERVED = 2'd3;
   localparam logic [CSR_IDX_W-1:0]    CSR_UNUSED    = 2'd3;
   localparam logic signed [RAW_W-1:0] RAW_MAX       = 16'sh7FFF;
   localparam logic signed [RAW_W-1:0] RAW_MIN       = 16'sh8000;
   localparam logic signed [RAW_W-1:0] RAW_ZERO      = 16'sh0000;
   localparam logic signed [RAW_W-1:0] RAW_NEG1      = 16'shFFFF;

   // every block input known from time zero
   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_payload_type      req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_payload_type      rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   int unsigned          fail_count;
   int unsigned          outstanding;

   // frames waiting to be offered on the request channel
   req_payload_type      frame_backlog [$];
   int                   sent_items  = 0;
   bit                   steady      = 1'b0;
   longint unsigned      cycle_count = 0;

   imu_sample_scale_and_offset_calibrate_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   isc_frame_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // request side: valid holds with the same frame until the transfer, random gaps
   // between frames unless the steady stretch is on
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (frame_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            req_valid <= 1'b1;
            req_data  <= frame_backlog.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side: random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // raw word with the rails and zero showing up often
   function automatic logic signed [RAW_W-1:0] rand_raw();
      case ($urandom_range(7))
         0:       return RAW_MIN;
         1:       return RAW_MAX;
         2:       return RAW_ZERO;
         default: return RAW_W'($urandom);
      endcase
   endfunction

   // small wobble around a resting value, now and then a large one
   function automatic logic signed [RAW_W-1:0] jitter();
      int j;
      if ($urandom_range(7) == 0) begin
         j = int'($urandom_range(8191)) - 4096;
      end else begin
         j = int'($urandom_range(127)) - 64;
      end
      return RAW_W'(j);
   endfunction

   function automatic logic [CSR_W-1:0] pick_scale();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return CSR_W'($urandom);
      endcase
   endfunction

   function automatic req_payload_type rand_frame(input logic [1:0] fn);
      req_payload_type f;
      f.func        = func_type'(fn);
      f.accel_x_raw = rand_raw();
      f.accel_y_raw = rand_raw();
      f.accel_z_raw = rand_raw();
      f.temp_word   = rand_raw();
      f.gyro_x_raw  = rand_raw();
      f.gyro_y_raw  = rand_raw();
      f.gyro_z_raw  = rand_raw();
      return f;
   endfunction

   function automatic req_payload_type mk_frame(input logic [1:0] fn,
         input logic signed [RAW_W-1:0] ax, input logic signed [RAW_W-1:0] ay,
         input logic signed [RAW_W-1:0] az, input logic signed [RAW_W-1:0] t,
         input logic signed [RAW_W-1:0] gx, input logic signed [RAW_W-1:0] gy,
         input logic signed [RAW_W-1:0] gz);
      req_payload_type f;
      f.func        = func_type'(fn);
      f.accel_x_raw = ax;
      f.accel_y_raw = ay;
      f.accel_z_raw = az;
      f.temp_word   = t;
      f.gyro_x_raw  = gx;
      f.gyro_y_raw  = gy;
      f.gyro_z_raw  = gz;
      return f;
   endfunction

   // queued only at a falling edge, so never in the same step the driver pops
   function automatic void push_frame(input req_payload_type f);
      frame_backlog.push_back(f);
      sent_items++;
   endfunction

   // register write, only called while the block is idle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   // wait for every queued frame to transfer and every result to come back
   task automatic drain();
      @(negedge clock);
      while (frame_backlog.size() != 0 || req_valid || outstanding != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // a sensor at rest: calibrate frames around one random resting value, converts
   // mixed in, and now and then a clear half way through to break the run
   task automatic cal_run(input int len, input bit broken);
      req_payload_type base;
      req_payload_type f;
      int              k;
      base = rand_frame(FUNC_CAL);
      for (k = 0; k < len; k++) begin
         f = base;
         f.accel_x_raw = base.accel_x_raw + jitter();
         f.accel_y_raw = base.accel_y_raw + jitter();
         f.accel_z_raw = base.accel_z_raw + jitter();
         f.gyro_x_raw  = base.gyro_x_raw + jitter();
         f.gyro_y_raw  = base.gyro_y_raw + jitter();
         f.gyro_z_raw  = base.gyro_z_raw + jitter();
         f.temp_word   = rand_raw();
         push_frame(f);
         if (broken && k == len / 2) begin
            push_frame(rand_frame(FUNC_CLEAR));
         end else if ($urandom_range(4) == 0) begin
            push_frame(rand_frame(FUNC_CONVERT));
         end
      end
      // look at the fresh offsets
      push_frame(rand_frame(FUNC_CONVERT));
   endtask

   task automatic run_phase(input int n_items, input int eff_len);
      int stop;
      stop = sent_items + n_items;
      while (sent_items < stop) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: begin
               cal_run((eff_len > 8) ? int'($urandom_range(1, 8)) : eff_len,
                       $urandom_range(9) == 0);
            end
            6, 7: begin
               push_frame(rand_frame(FUNC_CONVERT));
            end
            default: begin
               // any code, the reserved one and clear included
               push_frame(rand_frame(2'($urandom)));
            end
         endcase
      end
   endtask

   initial begin
      int               ph;
      int               eff_len;
      logic [CSR_W-1:0] len_word;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset defaults: rails, zero, minus one, reserved code, a partial run then clear
      push_frame(mk_frame(FUNC_CONVERT, RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX,
                          RAW_MAX, RAW_MAX, RAW_MAX));
      push_frame(mk_frame(FUNC_CONVERT, RAW_MIN, RAW_MIN, RAW_MIN, RAW_MIN,
                          RAW_MIN, RAW_MIN, RAW_MIN));
      push_frame(mk_frame(FUNC_CONVERT, RAW_ZERO, RAW_ZERO, RAW_ZERO, RAW_ZERO,
                          RAW_ZERO, RAW_ZERO, RAW_ZERO));
      push_frame(mk_frame(FUNC_CONVERT, RAW_NEG1, RAW_NEG1, RAW_NEG1, RAW_NEG1,
                          RAW_NEG1, RAW_NEG1, RAW_NEG1));
      push_frame(rand_frame(FUNC_RESERVED));
      push_frame(rand_frame(FUNC_CAL));
      push_frame(rand_frame(FUNC_CAL));
      push_frame(rand_frame(FUNC_CAL));
      push_frame(rand_frame(FUNC_CLEAR));
      push_frame(rand_frame(FUNC_CONVERT));
      drain();

      // one-frame runs: offsets from a single frame at the rails
      write_reg(CSR_CAL_SAMPLES, CSR_W'(1));
      push_frame(mk_frame(FUNC_CAL, RAW_MAX, RAW_MAX, RAW_MIN, RAW_MAX,
                          RAW_MAX, RAW_MAX, RAW_MAX));
      push_frame(mk_frame(FUNC_CONVERT, RAW_MIN, RAW_MIN, RAW_MAX, RAW_MIN,
                          RAW_MIN, RAW_MIN, RAW_MIN));
      drain();

      // full accel gain, zero gyro gain: z offset pinned at the low rail, so the
      // corrected values clip on both sides
      write_reg(CSR_ACCEL_SCALE, '1);
      write_reg(CSR_GYRO_SCALE, '0);
      push_frame(mk_frame(FUNC_CAL, RAW_MAX, RAW_MIN, RAW_MIN, RAW_ZERO,
                          RAW_MAX, RAW_MIN, RAW_MAX));
      push_frame(mk_frame(FUNC_CONVERT, RAW_MIN, RAW_MAX, RAW_MAX, RAW_MAX,
                          RAW_MIN, RAW_MAX, RAW_MIN));
      drain();

      // and the other way round
      write_reg(CSR_ACCEL_SCALE, '0);
      write_reg(CSR_GYRO_SCALE, '1);
      push_frame(mk_frame(FUNC_CONVERT, RAW_MAX, RAW_MAX, RAW_MAX, RAW_MIN,
                          RAW_MIN, RAW_MAX, RAW_MIN));
      push_frame(mk_frame(FUNC_CAL, RAW_MIN, RAW_MIN, RAW_MIN, RAW_MIN,
                          RAW_MAX, RAW_MAX, RAW_MIN));
      push_frame(mk_frame(FUNC_CONVERT, RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX,
                          RAW_MIN, RAW_MIN, RAW_MAX));
      drain();

      // a write to the unused index must leave everything alone
      write_reg(CSR_UNUSED, '1);
      push_frame(rand_frame(FUNC_CONVERT));
      drain();

      // run length above the maximum, then lowered mid-run: next calibrate frame ends it
      write_reg(CSR_CAL_SAMPLES, '1);
      push_frame(rand_frame(FUNC_CAL));
      push_frame(rand_frame(FUNC_CAL));
      push_frame(rand_frame(FUNC_CAL));
      drain();
      write_reg(CSR_CAL_SAMPLES, 16'hE002);
      push_frame(rand_frame(FUNC_CAL));
      push_frame(rand_frame(FUNC_CONVERT));
      drain();

      // run length of zero acts as one
      write_reg(CSR_CAL_SAMPLES, '0);
      push_frame(rand_frame(FUNC_CAL));
      push_frame(rand_frame(FUNC_CLEAR));
      push_frame(rand_frame(FUNC_CONVERT));
      drain();

      // random phases, new gains and run length in each, one phase without idling
      for (ph = 0; ph < RAND_PHASES; ph++) begin
         steady = (ph == CALM_PHASE);
         write_reg(CSR_ACCEL_SCALE, pick_scale());
         write_reg(CSR_GYRO_SCALE, pick_scale());
         if (ph == LONG_PHASE) begin
            len_word = CSR_W'(DEF_MAX_CAL_SAMPLES);
         end else if (ph == ZERO_PHASE) begin
            len_word = '0;
         end else begin
            len_word = {3'($urandom), 13'($urandom_range(1, 6))};
         end
         write_reg(CSR_CAL_SAMPLES, len_word);
         if (len_word[SAMPLES_W-1:0] == 0) begin
            eff_len = 1;
         end else if (len_word[SAMPLES_W-1:0] > DEF_MAX_CAL_SAMPLES) begin
            eff_len = DEF_MAX_CAL_SAMPLES;
         end else begin
            eff_len = len_word[SAMPLES_W-1:0];
         end
         run_phase(PHASE_ITEMS, eff_len);
         drain();
      end
      steady = 1'b0;

      drain();
      if (fail_count == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
